>>> hdl/aft_pkg.sv
`default_nettype none
package aft_pkg;

  // defaults for the top-level parameters
  localparam int CHANNELS_DEF    = 2;
  localparam int QUEUE_DEPTH_DEF = 4;

  // framing constants
  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] LEN_HI     = 8'h00;
  localparam logic [7:0] CKSUM_INIT = 8'hFF;

  // byte positions within the bytes sent for one item
  typedef enum logic [2:0] {
    STEP_START,
    STEP_LEN_HI,
    STEP_LEN_LO,
    STEP_DATA,
    STEP_CKSUM
  } step_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic       ch;
    logic       hdr;    // header bytes go first
    logic       tail;   // checksum byte goes last
    logic       empty;  // no payload byte
    logic [7:0] data;
    logic [7:0] len;
    logic [7:0] cksum;
  } desc_t;

endpackage
`default_nettype wire

>>> hdl/aft_front.sv
`default_nettype none
module aft_front #(
  parameter int CHANNELS = aft_pkg::CHANNELS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_channel,
  input  wire logic [7:0]    in_payload_byte,
  input  wire logic          in_first_byte,
  input  wire logic          in_last_byte,
  input  wire logic [7:0]    in_frame_length,
  input  wire logic          in_no_payload,
  input  wire logic          q_full,
  output logic               push,
  output aft_pkg::desc_t     push_desc
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]      cksum_r   [CHANNELS];
  logic [7:0]      cksum_nxt;
  logic            ch_red;
  logic [CH_W-1:0] ch_idx;
  logic [7:0]      base;
  logic [7:0]      diff;
  logic            restart;
  logic            close;

  // classify the item and work out its checksum
  always_comb begin
    ch_red    = (CHANNELS > 1) ? in_channel : 1'b0;
    ch_idx    = CH_W'(ch_red);
    restart   = in_first_byte | in_no_payload;
    close     = in_last_byte | in_no_payload;
    base      = restart ? aft_pkg::CKSUM_INIT : cksum_r[ch_idx];
    diff      = base - in_payload_byte;
    cksum_nxt = close ? aft_pkg::CKSUM_INIT : diff;

    in_ready        = !q_full;
    push            = in_valid && !q_full;
    push_desc.ch    = ch_red;
    push_desc.hdr   = restart;
    push_desc.tail  = close;
    push_desc.empty = in_no_payload;
    push_desc.data  = in_payload_byte;
    push_desc.len   = in_no_payload ? 8'h00 : in_frame_length;
    push_desc.cksum = in_no_payload ? aft_pkg::CKSUM_INIT : diff;
  end

  // per-channel running checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cksum_r[i] <= aft_pkg::CKSUM_INIT;
      end
    end else if (push) begin
      cksum_r[ch_idx] <= cksum_nxt;
    end
  end

  // a closed frame leaves its channel clean
  a_close_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (push && close) |=> (cksum_r[$past(ch_idx)] == aft_pkg::CKSUM_INIT))
    else $error("checksum not restored after frame close");

endmodule
`default_nettype wire

>>> hdl/aft_queue.sv
`default_nettype none
module aft_queue #(
  parameter int DEPTH = aft_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire aft_pkg::desc_t push_desc,
  input  wire logic           pop,
  output aft_pkg::desc_t      head,
  output logic                full,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  aft_pkg::desc_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
    full  = (count_r == CNT_W'(DEPTH));
    empty = (count_r == '0);
    head  = mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> hdl/aft_back.sv
`default_nettype none
module aft_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire aft_pkg::desc_t head,
  input  wire logic           q_empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_channel,
  output logic [7:0]          out_tx_byte,
  output logic                out_frame_end,
  output logic                out_last_of_run
);

  aft_pkg::step_t step_r, step_nxt;
  aft_pkg::step_t cur;
  aft_pkg::step_t end_step;
  logic           active_r, active_nxt;
  logic           load;
  logic           at_end;
  logic [7:0]     byte_sel;

  logic           out_valid_r, out_valid_nxt;
  logic           channel_r;
  logic [7:0]     tx_byte_r;
  logic           frame_end_r;
  logic           last_r;

  // byte sequencer for the item at the queue head
  always_comb begin
    cur      = active_r ? step_r
                        : (head.hdr ? aft_pkg::STEP_START : aft_pkg::STEP_DATA);
    end_step = head.tail ? aft_pkg::STEP_CKSUM : aft_pkg::STEP_DATA;
    at_end   = (cur == end_step);
    load     = !q_empty && (!out_valid_r || out_ready);
    pop      = load && at_end;

    case (cur)
      aft_pkg::STEP_START:  byte_sel = aft_pkg::START_BYTE;
      aft_pkg::STEP_LEN_HI: byte_sel = aft_pkg::LEN_HI;
      aft_pkg::STEP_LEN_LO: byte_sel = head.len;
      aft_pkg::STEP_DATA:   byte_sel = head.data;
      aft_pkg::STEP_CKSUM:  byte_sel = head.cksum;
      default:              byte_sel = head.data;
    endcase

    case (cur)
      aft_pkg::STEP_START:  step_nxt = aft_pkg::STEP_LEN_HI;
      aft_pkg::STEP_LEN_HI: step_nxt = aft_pkg::STEP_LEN_LO;
      aft_pkg::STEP_LEN_LO: step_nxt = head.empty ? aft_pkg::STEP_CKSUM
                                                  : aft_pkg::STEP_DATA;
      aft_pkg::STEP_DATA:   step_nxt = aft_pkg::STEP_CKSUM;
      default:              step_nxt = aft_pkg::STEP_START;
    endcase

    active_nxt = active_r;
    if (load) begin
      active_nxt = !at_end;
    end

    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= aft_pkg::STEP_START;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r <= step_nxt;
      end
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      channel_r   <= head.ch;
      tx_byte_r   <= byte_sel;
      frame_end_r <= (cur == aft_pkg::STEP_CKSUM);
      last_r      <= at_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = channel_r;
  assign out_tx_byte     = tx_byte_r;
  assign out_frame_end   = frame_end_r;
  assign out_last_of_run = last_r;

  // the checksum byte always closes its item's bytes
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r) |-> last_r)
    else $error("checksum byte not marked last of run");

  // mid-item the head item must still be queued
  a_active_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !q_empty)
    else $error("sequencer active with empty queue");

endmodule
`default_nettype wire

>>> hdl/api_frame_transmitter.sv
`default_nettype none
// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    channel, payload_byte, first/last, length, no_payload
// out_     output     out_valid / out_ready  channel, tx_byte, frame_end, last_of_run
//
// a mid-frame payload item gives one byte, a last item two, a first four, first and last five,
// an empty frame four; the byte sequencer sends one per cycle unless out_ready stalls it.
// input accepts whenever the item queue (QUEUE_DEPTH entries) has room, so the
// front keeps taking items while the output register waits on out_ready.
// rst_n is synchronous, active low; it sets every channel checksum to 0xFF and empties
// the queue and output register.
module api_frame_transmitter #(
  parameter int CHANNELS    = aft_pkg::CHANNELS_DEF,
  parameter int QUEUE_DEPTH = aft_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_channel,
  input  wire logic [7:0] in_payload_byte,
  input  wire logic       in_first_byte,
  input  wire logic       in_last_byte,
  input  wire logic [7:0] in_frame_length,
  input  wire logic       in_no_payload,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_channel,
  output logic [7:0]      out_tx_byte,
  output logic            out_frame_end,
  output logic            out_last_of_run
);

  aft_pkg::desc_t push_desc;
  aft_pkg::desc_t head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // front: checksum and classification
  aft_front #(.CHANNELS(CHANNELS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_payload_byte (in_payload_byte),
    .in_first_byte   (in_first_byte),
    .in_last_byte    (in_last_byte),
    .in_frame_length (in_frame_length),
    .in_no_payload   (in_no_payload),
    .q_full          (q_full),
    .push            (push),
    .push_desc       (push_desc)
  );

  // item queue between front and back
  aft_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: byte sequencer and output register
  aft_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_tx_byte     (out_tx_byte),
    .out_frame_end   (out_frame_end),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

// predicts the byte stream of the frame transmitter and checks it in order
class frame_checker;
  typedef struct packed {
    logic       ch;
    logic [7:0] tx;
    logic       fend;
    logic       run_end;
  } tx_rec_t;

  logic [7:0] cksum [2];
  tx_rec_t    expected_bytes[$];
  int         errors;
  int         bytes_checked;

  function new();
    cksum[0] = aft_pkg::CKSUM_INIT;
    cksum[1] = aft_pkg::CKSUM_INIT;
    errors = 0;
    bytes_checked = 0;
  endfunction

  // work out the bytes one accepted item causes
  function void predict_item(logic ch, logic [7:0] data, logic first, logic last,
                             logic [7:0] len, logic empty);
    tx_rec_t run[$];
    if (empty) begin
      cksum[ch] = aft_pkg::CKSUM_INIT;
      run.push_back(tx_rec_t'{ch, aft_pkg::START_BYTE, 1'b0, 1'b0});
      run.push_back(tx_rec_t'{ch, aft_pkg::LEN_HI, 1'b0, 1'b0});
      run.push_back(tx_rec_t'{ch, 8'h00, 1'b0, 1'b0});
      run.push_back(tx_rec_t'{ch, aft_pkg::CKSUM_INIT, 1'b1, 1'b0});
    end else begin
      // header restarts the checksum
      if (first) begin
        cksum[ch] = aft_pkg::CKSUM_INIT;
        run.push_back(tx_rec_t'{ch, aft_pkg::START_BYTE, 1'b0, 1'b0});
        run.push_back(tx_rec_t'{ch, aft_pkg::LEN_HI, 1'b0, 1'b0});
        run.push_back(tx_rec_t'{ch, len, 1'b0, 1'b0});
      end
      cksum[ch] = cksum[ch] - data;
      run.push_back(tx_rec_t'{ch, data, 1'b0, 1'b0});
      if (last) begin
        run.push_back(tx_rec_t'{ch, cksum[ch], 1'b1, 1'b0});
        cksum[ch] = aft_pkg::CKSUM_INIT;
      end
    end
    run[run.size()-1].run_end = 1'b1;
    foreach (run[i]) expected_bytes.push_back(run[i]);
  endfunction

  // compare one sent byte with the oldest prediction
  function void check_byte(logic ch, logic [7:0] tx, logic fend, logic run_end);
    tx_rec_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected byte ch=%0d tx=%02h end=%0d lor=%0d",
               $time, ch, tx, fend, run_end);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    bytes_checked++;
    if (want.ch !== ch || want.tx !== tx || want.fend !== fend ||
        want.run_end !== run_end) begin
      $display("%0t: mismatch expected ch=%0d tx=%02h end=%0d lor=%0d,",
               $time, want.ch, want.tx, want.fend, want.run_end);
      $display("%0t:          got ch=%0d tx=%02h end=%0d lor=%0d",
               $time, ch, tx, fend, run_end);
      errors++;
    end
  endfunction

  function int outstanding();
    return expected_bytes.size();
  endfunction
endclass

module tb;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 260;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_channel = 1'b0;
  logic [7:0] in_payload_byte = 8'h00;
  logic       in_first_byte = 1'b0;
  logic       in_last_byte = 1'b0;
  logic [7:0] in_frame_length = 8'h00;
  logic       in_no_payload = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_channel;
  logic [7:0] out_tx_byte;
  logic       out_frame_end;
  logic       out_last_of_run;

  frame_checker sb = new();
  logic calm = 1'b0;
  int   items_sent = 0;
  int   empty_frames = 0;
  int   idle_cycles = 0;

  api_frame_transmitter u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_channel     (in_channel),
    .in_payload_byte(in_payload_byte),
    .in_first_byte  (in_first_byte),
    .in_last_byte   (in_last_byte),
    .in_frame_length(in_frame_length),
    .in_no_payload  (in_no_payload),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_tx_byte    (out_tx_byte),
    .out_frame_end  (out_frame_end),
    .out_last_of_run(out_last_of_run)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // receiver stalls, none during the calm stretch
  always @(negedge clk) begin
    out_ready <= (calm || !rst_n) ? 1'b1 : ($urandom_range(99) >= 31);
  end

  // note accepted items, then check sent bytes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.predict_item(in_channel, in_payload_byte, in_first_byte, in_last_byte,
                        in_frame_length, in_no_payload);
        items_sent++;
        if (in_no_payload) empty_frames++;
      end
      if (out_valid && out_ready)
        sb.check_byte(out_channel, out_tx_byte, out_frame_end, out_last_of_run);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: no progress for %0d cycles", STALL_LIMIT);
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one item at a falling edge and hold it until accepted
  task automatic send_item(input logic ch, input logic [7:0] data, input logic first,
                           input logic last, input logic [7:0] len, input logic empty);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_channel      <= ch;
    in_payload_byte <= data;
    in_first_byte   <= first;
    in_last_byte    <= last;
    in_frame_length <= len;
    in_no_payload   <= empty;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // random noise item, every field free
  task automatic send_noise();
    send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  initial begin
    int         left [2];
    int         n;
    int         count;
    logic       ch;
    logic [7:0] len;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty frames, marks and other fields ignored
    send_item(1'b0, 8'hA5, 1'b0, 1'b0, 8'h33, 1'b1);
    send_item(1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1);
    // single-byte frames at the extremes
    send_item(1'b0, 8'h00, 1'b1, 1'b1, 8'h01, 1'b0);
    send_item(1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0);
    // interleaved frames on both channels
    send_item(1'b0, 8'h01, 1'b1, 1'b0, 8'h03, 1'b0);
    send_item(1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0);
    send_item(1'b1, 8'h7F, 1'b0, 1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 8'h55, 1'b0, 1'b1, 8'hAA, 1'b0);
    // headerless frame after a checksum starts clean
    send_item(1'b1, 8'h10, 1'b0, 1'b0, 8'h00, 1'b0);
    send_item(1'b1, 8'h20, 1'b0, 1'b1, 8'h00, 1'b0);
    // lone bytes with no marks, then a closing byte
    send_item(1'b0, 8'hFE, 1'b0, 1'b0, 8'h12, 1'b0);
    send_item(1'b0, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'h03, 1'b0, 1'b1, 8'h00, 1'b0);
    // empty frame in the middle of an open frame resets its checksum
    send_item(1'b1, 8'h44, 1'b1, 1'b0, 8'h05, 1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
    send_item(1'b1, 8'h66, 1'b0, 1'b1, 8'h00, 1'b0);
    // stated length disagrees with the byte count
    send_item(1'b0, 8'hC3, 1'b1, 1'b0, 8'hC8, 1'b0);
    send_item(1'b0, 8'h3C, 1'b0, 1'b1, 8'h00, 1'b0);
    // restart of a frame that was never closed
    send_item(1'b1, 8'h99, 1'b1, 1'b0, 8'h02, 1'b0);
    send_item(1'b1, 8'h11, 1'b1, 1'b1, 8'h01, 1'b0);

    // random part: mostly interleaved well-formed frames, some noise
    left[0] = 0;
    left[1] = 0;
    for (count = 0; count < RANDOM_ITEMS; count++) begin
      calm = (count >= 120 && count < 170);
      if ($urandom_range(99) < 18) begin
        send_noise();
      end else begin
        ch = 1'($urandom_range(1));
        if (left[ch] == 0) begin
          n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(1, 6);
          len = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'(n);
          left[ch] = n - 1;
          send_item(ch, 8'($urandom_range(255)), 1'b1, n == 1, len, 1'b0);
        end else begin
          left[ch]--;
          send_item(ch, 8'($urandom_range(255)), 1'b0, left[ch] == 0,
                    8'($urandom_range(255)), 1'b0);
        end
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain, then allow for any stray bytes
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d items (%0d empty frames) on both channels, %0d bytes checked",
             items_sent, empty_frames, sb.bytes_checked);
    $display("tb: covered single-byte, headerless, restarted and mislabelled frames");
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

>>> api_frame_transmitter.f
hdl/aft_pkg.sv
hdl/aft_front.sv
hdl/aft_queue.sv
hdl/aft_back.sv
hdl/api_frame_transmitter.sv
bench/tb.sv
